/* src/cpsp_pkg.sv */
package cpsp_pkg;

    // datapath widths
    localparam int ACC_W     = 44;
    localparam int MAG_W     = 33;
    localparam int GAIN_W    = 32;
    localparam int PROD_W    = MAG_W + GAIN_W;
    localparam int CFG_IDX_W = 3;

    // fixed thresholds of the controller
    localparam int WRAP_JUMP     = 6000;
    localparam int TOL_POSITION  = 1000;
    localparam int TOL_SPEED     = 20;
    localparam int CURRENT_LIMIT = 16384;
    localparam int SPEED_MAX     = 32767;

    typedef enum logic [1:0] {
        CMD_SPEED    = 2'd0,
        CMD_POSITION = 2'd1,
        CMD_CAPTURE  = 2'd2
    } cmd_t;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_SPEED_KP     = 3'd0,
        CFG_SPEED_KI     = 3'd1,
        CFG_SPEED_KD     = 3'd2,
        CFG_POSITION_KP  = 3'd3,
        CFG_POSITION_KI  = 3'd4,
        CFG_POSITION_KD  = 3'd5,
        CFG_REVERSED     = 3'd6,
        CFG_DEGREE_SCALE = 3'd7
    } cfg_index_t;

    typedef struct packed {
        logic [1:0]         cmd;
        logic [12:0]        raw_angle;
        logic signed [15:0] raw_speed;
        logic signed [31:0] target_speed;
        logic signed [31:0] target_degrees;
    } in_item_t;

    typedef struct packed {
        logic signed [15:0] drive_current;
        logic               drive_valid;
        logic               at_target;
        logic signed [31:0] position;
        logic signed [15:0] speed;
    } out_item_t;

    // saturate a wide signed value to 32 bits
    function automatic logic signed [31:0] sat32(input logic signed [ACC_W-1:0] v);
        logic [ACC_W-32:0] upper;
        upper = v[ACC_W-1:31];
        if (upper == '0 || upper == '1)
        begin
            return v[31:0];
        end
        else if (v[ACC_W-1])
        begin
            return 32'sh8000_0000;
        end
        else
        begin
            return 32'sh7fff_ffff;
        end
    endfunction

endpackage

/* src/cascaded_position_speed_pid_unit.sv */
// Cascaded position / speed PID controller for one geared motor.
// Input channel (in_valid, in_stall, in_item): one feedback sample plus a command per
// control tick; a transfer happens when in_valid is high and in_stall is low.
// Output channel (out_valid, out_stall, out_item): exactly one result per input item.
// Configuration: cfg_write with cfg_index and cfg_data writes one gain or mode register;
// write only while the block is idle.
// Sequencer steps from input transfer to out_valid; a new item is taken only after the
// previous one has been loaded into the output register:
//   speed mode     S_UNWRAP, S_POS, S_ERR, S_SUM, S_MUL_P, S_MUL_I, S_MUL_D, S_ACC, S_LOOP, S_DONE
//   position mode  as speed mode with S_GOAL_M, S_GOAL_A before S_ERR; S_ERR to S_LOOP run twice
//   capture/other  S_UNWRAP, S_POS, S_DONE
// A single shared 33x32 multiplier forms the PID products (six in position mode, three
// in speed mode) and the degree scaling one after another under a small sequencer.
// in_stall is low only while the sequencer waits for an item. The result sits in an
// output register; if out_stall holds the previous result there, the sequencer waits
// with the new one until that register frees up.
// Reset (rst_n low, asynchronous) loads the default tuning, zeroes turn count, home,
// integrators and settle counter, and empties the output register.
module cascaded_position_speed_pid_unit #(
    parameter int COUNTS_PER_TURN = 8191,
    parameter int SETTLE_TICKS    = 100
) (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                in_valid,
    output logic                                in_stall,
    input  cpsp_pkg::in_item_t                  in_item,
    output logic                                out_valid,
    input  logic                                out_stall,
    output cpsp_pkg::out_item_t                 out_item,
    input  logic                                cfg_write,
    input  logic [cpsp_pkg::CFG_IDX_W-1:0]      cfg_index,
    input  logic [31:0]                         cfg_data
);

    localparam int AW = cpsp_pkg::ACC_W;
    localparam int MW = cpsp_pkg::MAG_W;
    localparam int PW = cpsp_pkg::PROD_W;
    localparam int SETTLE_W = $clog2(SETTLE_TICKS + 2);
    localparam logic [SETTLE_W-1:0] SETTLE_LAST = SETTLE_W'(SETTLE_TICKS);
    localparam logic [SETTLE_W-1:0] SETTLE_CAP  = SETTLE_W'(SETTLE_TICKS + 1);
    localparam logic [31:0] TURN_STEP = 32'(COUNTS_PER_TURN);
    localparam logic signed [13:0] JUMP = 14'(cpsp_pkg::WRAP_JUMP);
    localparam logic signed [31:0] TOL_POS = 32'(cpsp_pkg::TOL_POSITION);
    localparam logic signed [15:0] TOL_SPD = 16'(cpsp_pkg::TOL_SPEED);
    localparam logic signed [AW-1:0] ACC_LIMIT = AW'(cpsp_pkg::CURRENT_LIMIT);
    localparam logic signed [15:0] CUR_LIMIT = 16'(cpsp_pkg::CURRENT_LIMIT);
    localparam logic signed [16:0] SPD_MAX = 17'(cpsp_pkg::SPEED_MAX);

    typedef enum logic [12:0] {
        S_IDLE   = 13'b0000000000001,
        S_UNWRAP = 13'b0000000000010,
        S_POS    = 13'b0000000000100,
        S_GOAL_M = 13'b0000000001000,
        S_GOAL_A = 13'b0000000010000,
        S_ERR    = 13'b0000000100000,
        S_SUM    = 13'b0000001000000,
        S_MUL_P  = 13'b0000010000000,
        S_MUL_I  = 13'b0000100000000,
        S_MUL_D  = 13'b0001000000000,
        S_ACC    = 13'b0010000000000,
        S_LOOP   = 13'b0100000000000,
        S_DONE   = 13'b1000000000000
    } state_t;

    state_t state_reg;

    // configuration
    logic [31:0] speed_kp_reg, speed_ki_reg, speed_kd_reg;
    logic [31:0] position_kp_reg, position_ki_reg, position_kd_reg;
    logic        reversed_reg;
    logic [31:0] degree_scale_reg;

    // controller state
    logic [12:0]          prev_angle_reg;
    logic [31:0]          turn_off_reg;
    logic [31:0]          home_reg;
    logic signed [31:0]   spd_sum_reg, spd_prev_reg;
    logic signed [31:0]   pos_sum_reg, pos_prev_reg;
    logic [SETTLE_W-1:0]  settle_reg;

    // per-item working registers
    cpsp_pkg::in_item_t   in_reg;
    logic signed [15:0]   spd_reg;
    logic [31:0]          posu_reg;
    logic signed [31:0]   setpoint_reg;
    logic signed [31:0]   err_reg;
    logic signed [32:0]   diff_reg;
    logic                 outer_reg;
    logic [PW-1:0]        prod_reg;
    logic                 neg_reg;
    logic signed [AW-1:0] acc_reg;
    logic signed [15:0]   cur_reg;
    logic                 drive_valid_reg;
    logic                 settled_reg;

    logic                 out_valid_reg;
    cpsp_pkg::out_item_t  out_reg;

    // datapath signals
    logic signed [13:0]   angle_diff;
    logic [31:0]          turn_off_next;
    logic signed [16:0]   spd_wide;
    logic signed [15:0]   spd_next;
    logic [31:0]          absang;
    logic [31:0]          rel_pos;
    logic [31:0]          posu_next;
    logic signed [AW-1:0] meas;
    logic signed [31:0]   err_next;
    logic signed [31:0]   sum_sel, prev_sel;
    logic signed [31:0]   sum_next;
    logic signed [32:0]   diff_next;
    logic                 settle_cond;
    logic [SETTLE_W-1:0]  settle_next;
    logic signed [32:0]   op;
    logic [31:0]          gain;
    logic                 op_neg;
    logic [MW-1:0]        op_mag;
    logic [PW-1:0]        prod_next;
    logic [40:0]          term;
    logic signed [AW-1:0] acc_add;
    logic [32:0]          t32;
    logic signed [31:0]   goal_next;
    logic signed [AW-1:0] u_wide;
    logic signed [15:0]   cur_next;
    logic                 accept;
    logic                 out_load;

    assign accept   = in_valid && (state_reg == S_IDLE);
    assign out_load = (state_reg == S_DONE) && (!out_valid_reg || !out_stall);

    always_comb
    begin
        // angle unwrap: big jumps are turn wraps
        angle_diff = $signed({1'b0, in_reg.raw_angle}) - $signed({1'b0, prev_angle_reg});
        if (angle_diff < -JUMP)
        begin
            turn_off_next = turn_off_reg + TURN_STEP;
        end
        else if (angle_diff > JUMP)
        begin
            turn_off_next = turn_off_reg - TURN_STEP;
        end
        else
        begin
            turn_off_next = turn_off_reg;
        end

        spd_wide = reversed_reg ? -17'(in_reg.raw_speed) : 17'(in_reg.raw_speed);
        spd_next = (spd_wide > SPD_MAX) ? 16'sh7fff : spd_wide[15:0];

        absang    = {19'b0, in_reg.raw_angle} + turn_off_reg;
        rel_pos   = (in_reg.cmd == cpsp_pkg::CMD_CAPTURE) ? 32'd0 : absang - home_reg;
        posu_next = reversed_reg ? 32'd0 - rel_pos : rel_pos;

        // loop error and integrator
        meas     = outer_reg ? AW'($signed(posu_reg)) : AW'(spd_reg);
        err_next = cpsp_pkg::sat32(AW'(setpoint_reg) - meas);
        sum_sel  = outer_reg ? pos_sum_reg : spd_sum_reg;
        prev_sel = outer_reg ? pos_prev_reg : spd_prev_reg;
        sum_next = cpsp_pkg::sat32(AW'(sum_sel) + AW'(err_reg));
        diff_next = 33'(err_reg) - 33'(prev_sel);

        settle_cond = (err_reg > -TOL_POS) && (err_reg < TOL_POS)
                   && (spd_reg > -TOL_SPD) && (spd_reg < TOL_SPD);
        if (!settle_cond)
        begin
            settle_next = '0;
        end
        else if (settle_reg <= SETTLE_LAST)
        begin
            settle_next = settle_reg + 1'b1;
        end
        else
        begin
            settle_next = settle_reg;
        end

        // shared multiplier operand select
        unique case (state_reg)
            S_GOAL_M:
            begin
                op   = 33'(in_reg.target_degrees);
                gain = degree_scale_reg;
            end
            S_MUL_P:
            begin
                op   = 33'(err_reg);
                gain = outer_reg ? position_kp_reg : speed_kp_reg;
            end
            S_MUL_I:
            begin
                op   = 33'(sum_sel);
                gain = outer_reg ? position_ki_reg : speed_ki_reg;
            end
            default:
            begin
                op   = diff_reg;
                gain = outer_reg ? position_kd_reg : speed_kd_reg;
            end
        endcase
        op_neg    = op[32];
        op_mag    = op_neg ? unsigned'(-op) : unsigned'(op);
        prod_next = PW'(op_mag) * PW'(gain);

        // Q8.24 product truncated toward zero: shift the magnitude, then apply sign
        term    = prod_reg[PW-1:24];
        acc_add = neg_reg ? acc_reg - $signed(AW'(term)) : acc_reg + $signed(AW'(term));

        t32       = prod_reg[PW-1:32];
        goal_next = cpsp_pkg::sat32(neg_reg ? -$signed(AW'(t32)) : $signed(AW'(t32)));

        u_wide = reversed_reg ? -acc_reg : acc_reg;
        if (u_wide > ACC_LIMIT)
        begin
            cur_next = CUR_LIMIT;
        end
        else if (u_wide < -ACC_LIMIT)
        begin
            cur_next = -CUR_LIMIT;
        end
        else
        begin
            cur_next = u_wide[15:0];
        end
    end

    // configuration registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            speed_kp_reg     <= 32'd83886080;
            speed_ki_reg     <= 32'd838861;
            speed_kd_reg     <= 32'd134217728;
            position_kp_reg  <= 32'd1006633;
            position_ki_reg  <= 32'd0;
            position_kd_reg  <= 32'd134218;
            reversed_reg     <= 1'b0;
            degree_scale_reg <= 32'd28555064;
        end
        else if (cfg_write)
        begin
            unique case (cpsp_pkg::cfg_index_t'(cfg_index))
                cpsp_pkg::CFG_SPEED_KP:     speed_kp_reg     <= cfg_data;
                cpsp_pkg::CFG_SPEED_KI:     speed_ki_reg     <= cfg_data;
                cpsp_pkg::CFG_SPEED_KD:     speed_kd_reg     <= cfg_data;
                cpsp_pkg::CFG_POSITION_KP:  position_kp_reg  <= cfg_data;
                cpsp_pkg::CFG_POSITION_KI:  position_ki_reg  <= cfg_data;
                cpsp_pkg::CFG_POSITION_KD:  position_kd_reg  <= cfg_data;
                cpsp_pkg::CFG_REVERSED:     reversed_reg     <= cfg_data[0];
                cpsp_pkg::CFG_DEGREE_SCALE: degree_scale_reg <= cfg_data;
                default:                    reversed_reg     <= reversed_reg;
            endcase
        end
    end

    // sequencer and controller state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= S_IDLE;
            out_valid_reg  <= 1'b0;
            prev_angle_reg <= '0;
            turn_off_reg   <= '0;
            home_reg       <= '0;
            spd_sum_reg    <= '0;
            spd_prev_reg   <= '0;
            pos_sum_reg    <= '0;
            pos_prev_reg   <= '0;
            settle_reg     <= '0;
            outer_reg      <= 1'b0;
        end
        else
        begin
            if (out_valid_reg && !out_stall)
            begin
                out_valid_reg <= 1'b0;
            end
            if (out_load)
            begin
                out_valid_reg <= 1'b1;
            end

            unique case (state_reg)
                S_IDLE:
                begin
                    if (accept)
                    begin
                        state_reg <= S_UNWRAP;
                    end
                end
                S_UNWRAP:
                begin
                    prev_angle_reg <= in_reg.raw_angle;
                    turn_off_reg   <= turn_off_next;
                    state_reg      <= S_POS;
                end
                S_POS:
                begin
                    if (in_reg.cmd == cpsp_pkg::CMD_CAPTURE)
                    begin
                        home_reg <= absang;
                    end
                    unique case (in_reg.cmd)
                        cpsp_pkg::CMD_SPEED:
                        begin
                            outer_reg <= 1'b0;
                            state_reg <= S_ERR;
                        end
                        cpsp_pkg::CMD_POSITION:
                        begin
                            outer_reg <= 1'b1;
                            state_reg <= S_GOAL_M;
                        end
                        default:
                        begin
                            state_reg <= S_DONE;
                        end
                    endcase
                end
                S_GOAL_M: state_reg <= S_GOAL_A;
                S_GOAL_A: state_reg <= S_ERR;
                S_ERR:    state_reg <= S_SUM;
                S_SUM:
                begin
                    if (outer_reg)
                    begin
                        pos_sum_reg  <= sum_next;
                        pos_prev_reg <= err_reg;
                        settle_reg   <= settle_next;
                    end
                    else
                    begin
                        spd_sum_reg  <= sum_next;
                        spd_prev_reg <= err_reg;
                    end
                    state_reg <= S_MUL_P;
                end
                S_MUL_P: state_reg <= S_MUL_I;
                S_MUL_I: state_reg <= S_MUL_D;
                S_MUL_D: state_reg <= S_ACC;
                S_ACC:   state_reg <= S_LOOP;
                S_LOOP:
                begin
                    // outer loop output becomes the inner setpoint
                    if (outer_reg)
                    begin
                        outer_reg <= 1'b0;
                        state_reg <= S_ERR;
                    end
                    else
                    begin
                        state_reg <= S_DONE;
                    end
                end
                S_DONE:
                begin
                    if (out_load)
                    begin
                        state_reg <= S_IDLE;
                    end
                end
                default: state_reg <= S_IDLE;
            endcase
        end
    end

    // working registers
    always_ff @(posedge clk)
    begin
        unique case (state_reg)
            S_IDLE:
            begin
                if (accept)
                begin
                    in_reg          <= in_item;
                    cur_reg         <= '0;
                    drive_valid_reg <= 1'b0;
                    settled_reg     <= 1'b0;
                end
            end
            S_UNWRAP: spd_reg  <= spd_next;
            S_POS:
            begin
                posu_reg     <= posu_next;
                setpoint_reg <= in_reg.target_speed;
            end
            S_GOAL_M:
            begin
                prod_reg <= prod_next;
                neg_reg  <= op_neg;
            end
            S_GOAL_A: setpoint_reg <= goal_next;
            S_ERR:    err_reg      <= err_next;
            S_SUM:
            begin
                diff_reg <= diff_next;
                acc_reg  <= '0;
                if (outer_reg)
                begin
                    settled_reg <= (settle_next > SETTLE_LAST);
                end
            end
            S_MUL_P:
            begin
                prod_reg <= prod_next;
                neg_reg  <= op_neg;
            end
            S_MUL_I, S_MUL_D:
            begin
                acc_reg  <= acc_add;
                prod_reg <= prod_next;
                neg_reg  <= op_neg;
            end
            S_ACC: acc_reg <= acc_add;
            S_LOOP:
            begin
                if (outer_reg)
                begin
                    setpoint_reg <= cpsp_pkg::sat32(acc_reg);
                end
                else
                begin
                    cur_reg         <= cur_next;
                    drive_valid_reg <= 1'b1;
                end
            end
            S_DONE:
            begin
                if (out_load)
                begin
                    out_reg.drive_current <= cur_reg;
                    out_reg.drive_valid   <= drive_valid_reg;
                    out_reg.at_target     <= settled_reg;
                    out_reg.position      <= $signed(posu_reg);
                    out_reg.speed         <= spd_reg;
                end
            end
            default: acc_reg <= acc_reg;
        endcase
    end

    assign in_stall  = (state_reg != S_IDLE);
    assign out_valid = out_valid_reg;
    assign out_item  = out_reg;

    // current command stays inside the drive limit
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> (out_item.drive_current <= CUR_LIMIT
                       && out_item.drive_current >= -CUR_LIMIT))
        else $error("drive current outside limit");

    // settled is only reported together with a current command
    assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && out_item.at_target) |-> out_item.drive_valid)
        else $error("at_target without drive_valid");

    // no command means zero current
    assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && !out_item.drive_valid) |-> (out_item.drive_current == 16'sd0))
        else $error("nonzero current without drive_valid");

    // settle counter saturates one past the threshold
    assert property (@(posedge clk) disable iff (!rst_n)
        (settle_reg <= SETTLE_LAST || settle_reg == SETTLE_CAP))
        else $error("settle counter overrun");

endmodule
